// File: design/rwmf_pkg.sv
// ----------------------------------------------------------------------------
// rwmf_pkg
// Shared types, constants and helpers for the RGB window median filter.
// ----------------------------------------------------------------------------
package rwmf_pkg;

	localparam int MAX_HALF  = 3;
	localparam int MAX_WIDTH = 1024;
	localparam int LINES     = 2 * MAX_HALF;
	localparam int SIDE      = 2 * MAX_HALF + 1;
	localparam int WIN_N     = SIDE * SIDE;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int ROW_W     = 16;
	localparam int MOD_W     = $clog2(LINES);
	localparam int HALF_W    = $clog2(MAX_HALF + 1);
	localparam int CNT_W     = $clog2(WIN_N + 1);
	localparam int PIX_W     = 24;
	localparam int WID_W     = 11;
	localparam int QDEPTH    = 4;

	typedef enum logic [1:0] {
		REG_HALF   = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_HEIGHT = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [HALF_W-1:0] half;
		logic [WID_W-1:0]  width;
		logic [ROW_W-1:0]  height;
	} cfg_t;

	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic [COL_W-1:0] col;
		logic [MOD_W-1:0] row_mod;
		logic [ROW_W-1:0] out_row;
		logic [COL_W-1:0] out_col;
		logic             emit;
		logic             last;
	} item_t;

	// line store bank holding the row that lies 'back' rows above
	function automatic logic [MOD_W-1:0] slot_of(input logic [MOD_W-1:0] row_mod,
		input logic [MOD_W-1:0] back);
		logic [MOD_W:0] t;
		t = {1'b0, row_mod} + (MOD_W+1)'(LINES) - {1'b0, back};
		if (t >= (MOD_W+1)'(LINES)) begin
			t = t - (MOD_W+1)'(LINES);
		end
		return t[MOD_W-1:0];
	endfunction

endpackage

// File: design/rgb_window_median_filter.sv
// ----------------------------------------------------------------------------
// rgb_window_median_filter
// Per-channel median over a square window of a raster-order RGB stream.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while the output is not held off and gives one
// result per interior pixel at the same sustained rate; the figure is set by
// the six line-store banks, which are all read together at the incoming column,
// and by the eight-stage bit-by-bit median select. With the four-entry input
// queue empty, a pixel's result is offered once it has passed the queue, the
// line-store read, the window register, the eight select stages and the output
// register; it comes later when the pixel waits in the queue or the output is held off.
// Line stores are not cleared: after reset, feed whole frames starting from
// frame_start.
module rgb_window_median_filter import rwmf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // pix_blue, pix_green, pix_red
	input  logic        s_tuser,  // frame_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // med_blue, med_green, med_red, out_row, out_col
	output logic        m_tlast,  // frame_last
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [1:0]       half_q;
	logic [WID_W-1:0] width_q;
	logic [ROW_W-1:0] height_q;
	cfg_t             cfg;
	logic             q_full;
	logic             push;
	item_t            push_item;
	logic             pop;
	logic             head_valid;
	item_t            head_item;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q   <= 2'd1;
			width_q  <= WID_W'(640);
			height_q <= ROW_W'(480);
		end else if (wr_en) begin
			case (reg_idx_t'(paddr[3:2]))
				REG_HALF:   half_q   <= pwdata[1:0];
				REG_WIDTH:  width_q  <= pwdata[WID_W-1:0];
				REG_HEIGHT: height_q <= pwdata[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[3:2]))
			REG_HALF:   prdata = {30'd0, half_q};
			REG_WIDTH:  prdata = {21'd0, width_q};
			REG_HEIGHT: prdata = {16'd0, height_q};
			default:    prdata = '0;
		endcase
	end

	// hold out-of-range settings to the usable range
	always_comb begin
		cfg.half   = (half_q == 2'd0) ? HALF_W'(1) : HALF_W'(half_q);
		cfg.width  = (width_q == '0) ? WID_W'(1) :
			(width_q > WID_W'(MAX_WIDTH)) ? WID_W'(MAX_WIDTH) : width_q;
		cfg.height = (height_q == '0) ? ROW_W'(1) : height_q;
	end

	rwmf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	rwmf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	rwmf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule

// File: design/rwmf_front.sv
// ----------------------------------------------------------------------------
// rwmf_front
// Accepts pixels, tracks row and column and marks interior positions.
// ----------------------------------------------------------------------------
module rwmf_front import rwmf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [23:0]      s_tdata,
	input  logic             s_tuser,
	input  logic             q_full,
	output logic             push,
	output item_t            push_item
);

	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic [MOD_W-1:0] mod_q;
	logic [ROW_W-1:0] row;
	logic [COL_W-1:0] col;
	logic [MOD_W-1:0] rmod;
	logic             col_end;
	logic             row_end;
	logic [COL_W:0]   two_h;

	assign s_tready = !q_full;
	assign push     = s_tvalid && s_tready;

	assign row     = s_tuser ? '0 : row_q;
	assign col     = s_tuser ? '0 : col_q;
	assign rmod    = s_tuser ? '0 : mod_q;
	assign col_end = ({1'b0, col} + 1'b1) >= cfg.width;
	assign row_end = ({1'b0, row} + 1'b1) >= {1'b0, cfg.height};
	assign two_h   = (COL_W+1)'({cfg.half, 1'b0});

	always_comb begin
		push_item.pix     = s_tdata;
		push_item.col     = col;
		push_item.row_mod = rmod;
		push_item.out_row = row - ROW_W'(cfg.half);
		push_item.out_col = col - COL_W'(cfg.half);
		push_item.emit    = ({1'b0, row} >= (ROW_W+1)'(two_h)) && ({1'b0, col} >= two_h);
		push_item.last    = col_end && row_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			mod_q <= '0;
		end else if (push) begin
			if (col_end) begin
				col_q <= '0;
				if (row_end) begin
					row_q <= '0;
					mod_q <= '0;
				end else begin
					row_q <= row + 1'b1;
					mod_q <= (rmod == MOD_W'(LINES - 1)) ? '0 : rmod + 1'b1;
				end
			end else begin
				col_q <= col + 1'b1;
				row_q <= row;
				mod_q <= rmod;
			end
		end
	end

endmodule

// File: design/rwmf_queue.sv
// ----------------------------------------------------------------------------
// rwmf_queue
// Short FIFO between the front and the back.
// ----------------------------------------------------------------------------
module rwmf_queue import rwmf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  head_valid,
	output item_t head_item
);

	localparam int PTR_W = $clog2(QDEPTH);

	item_t            mem_q [QDEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [PTR_W:0]   cnt_q;

	assign full       = cnt_q == (PTR_W+1)'(QDEPTH);
	assign head_valid = cnt_q != '0;
	assign head_item  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (PTR_W+1)'(QDEPTH)) else $error("queue count overflow");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid) else $error("pop from empty queue");
	a_cnt_steady: assert property (@(posedge clk) disable iff (!arst_n)
		(push && pop) |=> $stable(cnt_q)) else $error("count moved on push and pop");
`endif

endmodule

// File: design/rwmf_back.sv
// ----------------------------------------------------------------------------
// rwmf_back
// Line stores, window and per-channel radix median select.
// ----------------------------------------------------------------------------
module rwmf_back import rwmf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        head_valid,
	input  item_t       head_item,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,
	output logic        m_tlast
);

	typedef struct packed {
		logic [2:0][WIN_N-1:0][7:0] val;
		logic [2:0][WIN_N-1:0]      cand;
		logic [2:0][CNT_W-1:0]      kr;
		logic [2:0][7:0]            med;
		item_t                      meta;
	} sel_t;

	logic                                en;
	logic [PIX_W-1:0]                    bank_rd [LINES];
	logic                                v_s1;
	item_t                               item_s1;
	logic                                v_s2;
	item_t                               meta_s2;
	logic [SIDE-1:0][SIDE-1:0][PIX_W-1:0] win_s2;
	logic [SIDE-1:0][SIDE-1:0][PIX_W-1:0] win_n;
	logic [2:0]                          side;
	sel_t                                sel_s [9];
	logic                                vld_s [9];
	logic                                out_valid_q;
	logic [55:0]                         out_data_q;
	logic                                out_last_q;

	assign en       = !out_valid_q || m_tready;
	assign pop      = en && head_valid;
	assign side     = {cfg.half, 1'b1};
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	// one bank per buffered row, all read together at the incoming column
	for (genvar b = 0; b < LINES; b++) begin : g_bank
		logic [PIX_W-1:0] mem [MAX_WIDTH];
		always_ff @(posedge clk) begin
			if (pop) begin
				bank_rd[b] <= mem[head_item.col];
				if (head_item.row_mod == MOD_W'(b)) begin
					mem[head_item.col] <= head_item.pix;
				end
			end
		end
	end

	always_comb begin
		logic [MOD_W-1:0] back;
		back  = '0;
		win_n = win_s2;
		for (int rr = 0; rr < SIDE; rr++) begin
			for (int cc = 0; cc < SIDE; cc++) begin
				if (rr < int'(side)) begin
					if (cc + 1 < int'(side)) begin
						win_n[rr][cc] = win_s2[rr][cc+1];
					end else if (cc == int'(side) - 1) begin
						if (rr == int'(side) - 1) begin
							win_n[rr][cc] = item_s1.pix;
						end else begin
							back = MOD_W'(int'(side) - 1 - rr);
							win_n[rr][cc] = bank_rd[slot_of(item_s1.row_mod, back)];
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= head_item;
			meta_s2 <= item_s1;
			if (v_s1) begin
				win_s2 <= win_n;
			end
		end
	end

	// seed of the select: window values, live positions, target rank
	always_comb begin
		sel_s[0]      = '0;
		sel_s[0].meta = meta_s2;
		for (int c = 0; c < 3; c++) begin
			case (cfg.half)
				HALF_W'(2): sel_s[0].kr[c] = CNT_W'(12);
				HALF_W'(3): sel_s[0].kr[c] = CNT_W'(24);
				default:    sel_s[0].kr[c] = CNT_W'(4);
			endcase
			for (int rr = 0; rr < SIDE; rr++) begin
				for (int cc = 0; cc < SIDE; cc++) begin
					sel_s[0].val[c][rr*SIDE+cc]  = win_s2[rr][cc][8*c +: 8];
					sel_s[0].cand[c][rr*SIDE+cc] = (rr < int'(side)) && (cc < int'(side));
				end
			end
		end
	end
	assign vld_s[0] = v_s2;

	// one result bit per stage, most significant first
	for (genvar t = 0; t < 8; t++) begin : g_sel
		sel_t nx;
		always_comb begin
			logic [WIN_N-1:0] zm;
			logic [CNT_W-1:0] c0;
			nx = sel_s[t];
			for (int c = 0; c < 3; c++) begin
				for (int i = 0; i < WIN_N; i++) begin
					zm[i] = sel_s[t].cand[c][i] && !sel_s[t].val[c][i][7-t];
				end
				c0 = CNT_W'($countones(zm));
				if (sel_s[t].kr[c] < c0) begin
					nx.cand[c]     = zm;
					nx.med[c][7-t] = 1'b0;
				end else begin
					nx.cand[c]     = sel_s[t].cand[c] & ~zm;
					nx.kr[c]       = sel_s[t].kr[c] - c0;
					nx.med[c][7-t] = 1'b1;
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				sel_s[t+1] <= nx;
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[t+1] <= 1'b0;
			end else if (en) begin
				vld_s[t+1] <= vld_s[t];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= head_valid;
			v_s2        <= v_s1;
			out_valid_q <= vld_s[8] && sel_s[8].meta.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= {6'd0, sel_s[8].meta.out_col, sel_s[8].meta.out_row,
				sel_s[8].med[2], sel_s[8].med[1], sel_s[8].med[0]};
			out_last_q <= sel_s[8].meta.last;
		end
	end

endmodule

// File: bench/rgb_median_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_median_checker
// Watches the pixel, result and register buses of the median filter, keeps
// its own model of the line stores and window, and scores every result.
// ----------------------------------------------------------------------------
module rgb_median_checker import rwmf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,  // pix_blue, pix_green, pix_red
	input  logic        s_tuser,  // frame_start
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [55:0] m_tdata,  // med_blue, med_green, med_red, out_row, out_col
	input  logic        m_tlast,  // frame_last
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fail_count,
	output int          pending,
	output int          median_count,
	output int          pixel_count
);

	typedef struct {
		logic [7:0]  blue;
		logic [7:0]  green;
		logic [7:0]  red;
		logic [15:0] row;
		logic [9:0]  col;
		logic        last;
	} median_res_t;

	median_res_t due_q[$];

	logic [23:0] line_mem [LINES][MAX_WIDTH];
	logic [23:0] win [SIDE][SIDE];
	logic [1:0]  half_r;
	logic [10:0] width_r;
	logic [15:0] height_r;
	int          row_n;
	int          col_n;

	initial begin
		fail_count   = 0;
		pending      = 0;
		median_count = 0;
		pixel_count  = 0;
		half_r       = 1;
		width_r      = 640;
		height_r     = 480;
		row_n        = 0;
		col_n        = 0;
		for (int i = 0; i < LINES; i++)
			for (int j = 0; j < MAX_WIDTH; j++)
				line_mem[i][j] = '0;
		for (int i = 0; i < SIDE; i++)
			for (int j = 0; j < SIDE; j++)
				win[i][j] = '0;
	end

	function automatic logic [7:0] mid_of(input logic [7:0] v[WIN_N], input int n);
		logic [7:0] a[WIN_N];
		logic [7:0] x;
		int         j;
		for (int i = 0; i < n; i++) begin
			x = v[i];
			j = i;
			while (j > 0 && a[j-1] > x) begin
				a[j] = a[j-1];
				j--;
			end
			a[j] = x;
		end
		return a[n/2];
	endfunction

	task automatic report(input string what, input int got, input int want);
		$display("[%0t] bad %s: got %0d, want %0d", $time, what, got, want);
		fail_count++;
	endtask

	task automatic advance_pixel(input logic [23:0] px, input logic fs);
		int          h, w, ht, s, row, col, slot, k;
		logic [7:0]  vb[WIN_N];
		logic [7:0]  vg[WIN_N];
		logic [7:0]  vr[WIN_N];
		median_res_t res;
		h  = half_r;
		w  = width_r;
		ht = height_r;
		if (h < 1) h = 1;
		if (h > MAX_HALF) h = MAX_HALF;
		if (w < 1) w = 1;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		if (ht < 1) ht = 1;
		s = 2 * h + 1;
		if (fs) begin
			row_n = 0;
			col_n = 0;
		end
		row = row_n;
		col = col_n % MAX_WIDTH;
		for (int r = 0; r < s; r++)
			for (int c = 0; c + 1 < s; c++)
				win[r][c] = win[r][c+1];
		// rightmost column: rows above from the line stores, newest pixel below
		for (int r = 0; r + 1 < s; r++) begin
			slot = (row % LINES + LINES - (s - 1 - r)) % LINES;
			win[r][s-1] = line_mem[slot][col];
		end
		win[s-1][s-1] = px;
		line_mem[row % LINES][col] = px;
		if (row >= 2 * h && col >= 2 * h) begin
			k = 0;
			for (int r = 0; r < s; r++)
				for (int c = 0; c < s; c++) begin
					vb[k] = win[r][c][7:0];
					vg[k] = win[r][c][15:8];
					vr[k] = win[r][c][23:16];
					k++;
				end
			res.blue  = mid_of(vb, k);
			res.green = mid_of(vg, k);
			res.red   = mid_of(vr, k);
			res.row   = 16'(row - h);
			res.col   = 10'(col - h);
			res.last  = (row + 1 >= ht) && (col + 1 >= w);
			due_q.push_back(res);
		end
		if (col + 1 >= w) begin
			col_n = 0;
			row_n = (row + 1 >= ht) ? 0 : row + 1;
		end else begin
			col_n = col + 1;
		end
	endtask

	always @(posedge clk) begin
		median_res_t want;
		if (arst_n) begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_HALF:   half_r   = pwdata[1:0];
					REG_WIDTH:  width_r  = pwdata[10:0];
					REG_HEIGHT: height_r = pwdata[15:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				advance_pixel(s_tdata, s_tuser);
				pixel_count++;
			end
			if (m_tvalid && m_tready) begin
				median_count++;
				if (due_q.size() == 0) begin
					report("unexpected result, row", m_tdata[39:24], -1);
				end else begin
					want = due_q.pop_front();
					if (m_tdata[7:0] !== want.blue)
						report("med_blue", m_tdata[7:0], want.blue);
					if (m_tdata[15:8] !== want.green)
						report("med_green", m_tdata[15:8], want.green);
					if (m_tdata[23:16] !== want.red)
						report("med_red", m_tdata[23:16], want.red);
					if (m_tdata[39:24] !== want.row)
						report("out_row", m_tdata[39:24], want.row);
					if (m_tdata[49:40] !== want.col)
						report("out_col", m_tdata[49:40], want.col);
					if (m_tlast !== want.last)
						report("frame_last", m_tlast, want.last);
				end
			end
			pending = due_q.size();
		end
	end

endmodule

// File: bench/rgb_window_median_filter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_window_median_filter_tb
// Streams directed and random RGB frames through the median filter under
// several window and image settings, with random stalls on both sides.
// ----------------------------------------------------------------------------
module rgb_window_median_filter_tb;
	import rwmf_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;
	logic        m_tlast;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int fail_count;
	int pending;
	int median_count;
	int pixel_count;
	int setting_count = 0;
	int hold_done = 0;
	bit hold_req = 0;
	bit no_gaps = 0;

	always #5 clk = ~clk;

	rgb_window_median_filter uut (.*);

	rgb_median_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.fail_count(fail_count), .pending(pending),
		.median_count(median_count), .pixel_count(pixel_count)
	);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic apb_write(input reg_idx_t idx, input logic [31:0] v);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 4'(idx) << 2;
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic configure(input int h, input int w, input int ht);
		apb_write(REG_HALF, h);
		apb_write(REG_WIDTH, w);
		apb_write(REG_HEIGHT, ht);
		setting_count++;
	endtask

	// hold tvalid high across back-to-back transfers; drop it only for a gap
	task automatic send_pixel(input logic [23:0] d, input logic fs);
		int g;
		g = no_gaps ? 0 : pick_gap();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		s_tuser  <= fs;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic send_frame(input int n, input logic fs_first);
		for (int i = 0; i < n; i++)
			send_pixel(24'($urandom), (i == 0) ? fs_first : 1'b0);
	endtask

	// drain every result, then allow for pixels still in flight
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	initial begin
		int stall;
		stall = 0;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_req = 0;
				hold_done++;
			end else if (stall > 0) begin
				m_tready <= 1'b0;
				stall--;
			end else begin
				m_tready <= 1'b1;
				if (!no_gaps && $urandom_range(0, 7) == 0)
					stall = pick_gap();
			end
		end
	end

	initial begin
		#20ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int  h, s, w, ht, nfr, n, cut;
		bit  first_phase;
		bit  fs_next;
		logic [23:0] d;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= 1'b0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// 3x3 frame of extreme values, then a second one that wraps in
		configure(1, 3, 3);
		for (int i = 0; i < 18; i++) begin
			case (i % 3)
				0: d = 24'h000000;
				1: d = 24'hFFFFFF;
				default: d = {8'h80, 8'h01, 8'hFE};
			endcase
			if (i >= 9 && i[0]) d = ~d;
			send_pixel(d, i == 0);
		end
		settle();

		// zero registers clamp to one: nothing fits the window
		configure(0, 0, 0);
		for (int i = 0; i < 4; i++)
			send_pixel(24'($urandom), i[0]);
		settle();

		// largest window
		configure(3, 9, 8);
		send_frame(72, 1'b1);
		settle();

		// tallest frame: a few rows only
		configure(3, 7, 65535);
		send_frame(7 * 9, 1'b1);
		settle();

		first_phase = 1;
		while (pixel_count < 1800) begin
			h = $urandom_range(1, 3);
			s = 2 * h + 1;
			w = ($urandom_range(0, 9) == 0) ? $urandom_range(1, s - 1) : $urandom_range(s, s + 8);
			ht = ($urandom_range(0, 9) == 0) ? $urandom_range(1, s - 1) : $urandom_range(s, s + 5);
			// the long hold needs a frame that yields plenty of results
			if (first_phase) begin
				w  = s + 8;
				ht = s + 5;
			end
			configure(h, w, ht);
			no_gaps = ($urandom_range(0, 4) == 0);
			if (first_phase) begin
				no_gaps = 1;
				hold_req = 1;
			end
			first_phase = 0;
			nfr = $urandom_range(1, 3);
			fs_next = 1;
			for (int f = 0; f < nfr; f++) begin
				n = w * ht;
				cut = n;
				if (n > 2 && $urandom_range(0, 9) == 0)
					cut = $urandom_range(1, n - 1);
				send_frame(cut, fs_next);
				// a cut frame forces frame_start; a whole one may wrap
				fs_next = (cut != n) ? 1'b1 : 1'($urandom_range(0, 1));
			end
			settle();
			no_gaps = 0;
		end

		$display("Run covered %0d pixels and %0d medians over %0d register settings,",
			pixel_count, median_count, setting_count);
		$display("window half sizes 0 to 3, clamped sizes and %0d long output hold(s).",
			hold_done);
		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// File: filelist.f
design/rwmf_pkg.sv
design/rwmf_front.sv
design/rwmf_queue.sv
design/rwmf_back.sv
design/rgb_window_median_filter.sv
bench/rgb_median_checker.sv
bench/rgb_window_median_filter_tb.sv
